// ===== hw/rtl/amof_pkg.sv =====
package amof_pkg;

	// Addressing mode codes
	localparam logic [3:0] MODE_IMP = 4'd0;
	localparam logic [3:0] MODE_ACC = 4'd1;
	localparam logic [3:0] MODE_IMM = 4'd2;
	localparam logic [3:0] MODE_ZP  = 4'd3;
	localparam logic [3:0] MODE_ZPX = 4'd4;
	localparam logic [3:0] MODE_ZPY = 4'd5;
	localparam logic [3:0] MODE_REL = 4'd6;
	localparam logic [3:0] MODE_ABS = 4'd7;
	localparam logic [3:0] MODE_ABX = 4'd8;
	localparam logic [3:0] MODE_ABY = 4'd9;
	localparam logic [3:0] MODE_IND = 4'd10;
	localparam logic [3:0] MODE_IZX = 4'd11;
	localparam logic [3:0] MODE_IZY = 4'd12;

	// Input item kinds
	localparam logic ITEM_START = 1'b0;
	localparam logic ITEM_DATA  = 1'b1;

	// Result kinds
	localparam logic RESULT_READ = 1'b0;
	localparam logic RESULT_DONE = 1'b1;

	// Extra cycle hints
	localparam logic [1:0] EXTRA_NONE  = 2'd0;
	localparam logic [1:0] EXTRA_CROSS = 2'd1;
	localparam logic [1:0] EXTRA_REL   = 2'd3;

	// Sequencer phase, one-hot
	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_OP1  = 6'b000010,
		PH_OP2  = 6'b000100,
		PH_PL   = 6'b001000,
		PH_PH   = 6'b010000,
		PH_VAL  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic        item_kind;
		logic [3:0]  mode;
		logic [15:0] prog_counter;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  accum;
		logic [7:0]  read_data;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [15:0] bus_address;
		logic [15:0] next_pc;
		logic [15:0] effective_address;
		logic [7:0]  operand_byte;
		logic [1:0]  extra_cycles;
	} result_t;

endpackage

// ===== hw/rtl/addressing_mode_operand_fetch_core.sv =====
// Channel | Handshake                    | Payload
// item    | item_valid / item_ready      | item   (item_t: start or read data)
// result  | result_valid / result_ready  | result (result_t: read request or done)
//
// Every accepted item gives exactly one result, registered and valid in the cycle after acceptance.
// One item per cycle while the result is taken: the next state and result come from one short decode between
// the state registers and the result register.
// item_ready is high while the result register is empty or is being taken.
// Reset clears the sequencer to idle and all retained address, PC and value state.
module addressing_mode_operand_fetch_core
	import amof_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// Sequencer state
	phase_t      phase_q, phase_n;
	logic [3:0]  mode_q, mode_n;
	logic [15:0] pc_q, pc_n;
	logic [7:0]  x_q, x_n;
	logic [7:0]  y_q, y_n;
	logic [7:0]  low_q, low_n;
	logic [15:0] ptr_q, ptr_n;
	logic [15:0] eff_q, eff_n;
	logic [7:0]  fetched_q, fetched_n;

	// Result register
	logic    res_valid_q;
	result_t res_q;
	result_t res_n;

	logic        accept;
	logic        done;
	logic [1:0]  extra;
	logic [15:0] req_addr;
	logic [7:0]  d;
	logic [7:0]  zp_x;
	logic [7:0]  zp_y;
	logic [7:0]  ptr_lo_inc;
	logic [15:0] base;
	logic [15:0] base_x;
	logic [15:0] base_y;

	assign item_ready   = !res_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Datapath helpers
	assign d          = item.read_data;
	assign zp_x       = d + x_q;
	assign zp_y       = d + y_q;
	assign ptr_lo_inc = ptr_q[7:0] + 8'd1;
	assign base       = {d, low_q};
	assign base_x     = base + {8'h00, x_q};
	assign base_y     = base + {8'h00, y_q};

	// Next state and result decode
	always_comb begin
		phase_n   = PH_IDLE;
		mode_n    = mode_q;
		pc_n      = pc_q;
		x_n       = x_q;
		y_n       = y_q;
		low_n     = low_q;
		ptr_n     = ptr_q;
		eff_n     = eff_q;
		fetched_n = fetched_q;
		done      = 1'b1;
		extra     = EXTRA_NONE;
		req_addr  = 16'h0000;

		if (item.item_kind == ITEM_START) begin
			mode_n = item.mode;
			pc_n   = item.prog_counter;
			x_n    = item.index_x;
			y_n    = item.index_y;
			if (item.mode == MODE_ACC) begin
				fetched_n = item.accum;
			end else if (item.mode != MODE_IMP && item.mode <= MODE_IZY) begin
				done     = 1'b0;
				req_addr = item.prog_counter;
				pc_n     = item.prog_counter + 16'd1;
				phase_n  = PH_OP1;
			end
		end else begin
			unique case (phase_q)
				PH_OP1: begin
					unique case (mode_q) inside
						MODE_IMM: begin
							fetched_n = d;
						end
						MODE_REL: begin
							fetched_n = d;
							extra     = EXTRA_REL;
						end
						MODE_ZP: begin
							eff_n    = {8'h00, d};
							done     = 1'b0;
							req_addr = {8'h00, d};
							phase_n  = PH_VAL;
						end
						MODE_ZPX: begin
							eff_n    = {8'h00, zp_x};
							done     = 1'b0;
							req_addr = {8'h00, zp_x};
							phase_n  = PH_VAL;
						end
						MODE_ZPY: begin
							eff_n    = {8'h00, zp_y};
							done     = 1'b0;
							req_addr = {8'h00, zp_y};
							phase_n  = PH_VAL;
						end
						MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND: begin
							low_n    = d;
							done     = 1'b0;
							req_addr = pc_q;
							pc_n     = pc_q + 16'd1;
							phase_n  = PH_OP2;
						end
						MODE_IZX: begin
							ptr_n    = {8'h00, zp_x};
							done     = 1'b0;
							req_addr = {8'h00, zp_x};
							phase_n  = PH_PL;
						end
						MODE_IZY: begin
							ptr_n    = {8'h00, d};
							done     = 1'b0;
							req_addr = {8'h00, d};
							phase_n  = PH_PL;
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
				PH_OP2: begin
					ptr_n = base;
					done  = 1'b0;
					if (mode_q == MODE_IND) begin
						req_addr = base;
						phase_n  = PH_PL;
					end else begin
						if (mode_q == MODE_ABX) begin
							eff_n = base_x;
						end else if (mode_q == MODE_ABY) begin
							eff_n = base_y;
						end else begin
							eff_n = base;
						end
						req_addr = eff_n;
						phase_n  = PH_VAL;
					end
				end
				PH_PL: begin
					// high pointer byte never leaves the page of the low byte
					low_n   = d;
					done    = 1'b0;
					phase_n = PH_PH;
					if (mode_q == MODE_IND) begin
						req_addr = {ptr_q[15:8], ptr_lo_inc};
					end else begin
						req_addr = {8'h00, ptr_lo_inc};
					end
				end
				PH_PH: begin
					ptr_n    = base;
					eff_n    = (mode_q == MODE_IZY) ? base_y : base;
					done     = 1'b0;
					req_addr = eff_n;
					phase_n  = PH_VAL;
				end
				PH_VAL: begin
					fetched_n = d;
					if ((mode_q == MODE_ABX || mode_q == MODE_ABY || mode_q == MODE_IZY) &&
						(ptr_q[15:8] != eff_q[15:8])) begin
						extra = EXTRA_CROSS;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end

		// Assemble the result from the updated state
		res_n.next_pc = pc_n;
		if (done) begin
			res_n.result_kind       = RESULT_DONE;
			res_n.bus_address       = 16'h0000;
			res_n.effective_address = eff_n;
			res_n.operand_byte      = fetched_n;
			res_n.extra_cycles      = extra;
		end else begin
			res_n.result_kind       = RESULT_READ;
			res_n.bus_address       = req_addr;
			res_n.effective_address = 16'h0000;
			res_n.operand_byte      = 8'h00;
			res_n.extra_cycles      = EXTRA_NONE;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			mode_q    <= MODE_IMP;
			pc_q      <= 16'h0000;
			x_q       <= 8'h00;
			y_q       <= 8'h00;
			low_q     <= 8'h00;
			ptr_q     <= 16'h0000;
			eff_q     <= 16'h0000;
			fetched_q <= 8'h00;
		end else if (accept) begin
			phase_q   <= phase_n;
			mode_q    <= mode_n;
			pc_q      <= pc_n;
			x_q       <= x_n;
			y_q       <= y_n;
			low_q     <= low_n;
			ptr_q     <= ptr_n;
			eff_q     <= eff_n;
			fetched_q <= fetched_n;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_n;
		end
	end

endmodule

// ===== hw/rtl/amof_checker.sv =====
module amof_checker
	import amof_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input item_t   item,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// An empty result register never blocks requests
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item_ready low with empty result register");

	// Every accepted request gives a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted request produced no result");

	// Unused fields of each result kind are zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		(result.result_kind == RESULT_DONE && result.bus_address == 16'h0000) ||
		(result.result_kind == RESULT_READ && result.effective_address == 16'h0000 &&
		 result.operand_byte == 8'h00 && result.extra_cycles == EXTRA_NONE))
		else $error("result carries stray fields");

	// A start in implied or accumulator mode finishes at once with the new PC
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.item_kind == ITEM_START &&
		(item.mode == MODE_IMP || item.mode == MODE_ACC) |=>
		result.result_kind == RESULT_DONE && result.next_pc == $past(item.prog_counter))
		else $error("implied start did not finish immediately");

endmodule

bind addressing_mode_operand_fetch_core amof_checker u_amof_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// ===== tb/addressing_mode_operand_fetch_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts each result of the operand fetch
// sequencer and compares it with what the core returns.
module addressing_mode_operand_fetch_checker
	import amof_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      fail_count,
	output int      pending
);

	localparam int PRINT_CAP = 40;

	// Shadow of the sequencer state
	phase_t      seq_phase;
	logic [3:0]  cur_mode;
	logic [15:0] pc_q;
	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic [7:0]  lo_q;
	logic [15:0] ptr_q;
	logic [15:0] ea_q;
	logic [7:0]  val_q;

	result_t awaited_results[$];
	result_t want;
	int      results_seen = 0;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] exp_val);
		if (fail_count < PRINT_CAP)
			$display("%0t: result %0d: %s: got %h, expected %h", $realtime, results_seen,
				what, got, exp_val);
		fail_count++;
	endtask

	// Bus read request; the next data item answers it
	function automatic result_t read_request(logic [15:0] addr, phase_t nxt);
		result_t r;
		r = '0;
		seq_phase = nxt;
		r.result_kind = RESULT_READ;
		r.bus_address = addr;
		r.next_pc = pc_q;
		return r;
	endfunction

	// Operand byte fetch from the program counter
	function automatic result_t pc_request(phase_t nxt);
		logic [15:0] addr;
		addr = pc_q;
		pc_q = pc_q + 16'd1;
		return read_request(addr, nxt);
	endfunction

	function automatic result_t done_result(logic [1:0] hint);
		result_t r;
		r = '0;
		seq_phase = PH_IDLE;
		r.result_kind = RESULT_DONE;
		r.next_pc = pc_q;
		r.effective_address = ea_q;
		r.operand_byte = val_q;
		r.extra_cycles = hint;
		return r;
	endfunction

	// One accepted request in, one expected result out
	function automatic result_t advance_sequencer(item_t it);
		logic [15:0] base;
		logic [7:0]  zp_sum;
		logic [7:0]  ptr_next_lo;
		logic        crossed;
		base = {it.read_data, lo_q};
		ptr_next_lo = ptr_q[7:0] + 8'd1;
		if (it.item_kind == ITEM_START) begin
			cur_mode = it.mode;
			pc_q = it.prog_counter;
			x_q = it.index_x;
			y_q = it.index_y;
			if (cur_mode == MODE_ACC)
				val_q = it.accum;
			// accumulator, implied and undefined codes finish at once
			if (cur_mode == MODE_ACC || cur_mode == MODE_IMP || cur_mode > MODE_IZY)
				return done_result(EXTRA_NONE);
			return pc_request(PH_OP1);
		end
		case (seq_phase)
			PH_OP1: begin
				case (cur_mode)
					MODE_IMM: begin
						val_q = it.read_data;
						return done_result(EXTRA_NONE);
					end
					MODE_REL: begin
						val_q = it.read_data;
						return done_result(EXTRA_REL);
					end
					MODE_ZP: begin
						ea_q = {8'h00, it.read_data};
						return read_request(ea_q, PH_VAL);
					end
					MODE_ZPX, MODE_ZPY: begin
						zp_sum = it.read_data + ((cur_mode == MODE_ZPX) ? x_q : y_q);
						ea_q = {8'h00, zp_sum};
						return read_request(ea_q, PH_VAL);
					end
					MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND: begin
						lo_q = it.read_data;
						return pc_request(PH_OP2);
					end
					MODE_IZX: begin
						zp_sum = it.read_data + x_q;
						ptr_q = {8'h00, zp_sum};
						return read_request(ptr_q, PH_PL);
					end
					MODE_IZY: begin
						ptr_q = {8'h00, it.read_data};
						return read_request(ptr_q, PH_PL);
					end
					default: return done_result(EXTRA_NONE);
				endcase
			end
			PH_OP2: begin
				ptr_q = base;
				if (cur_mode == MODE_IND)
					return read_request(ptr_q, PH_PL);
				if (cur_mode == MODE_ABX)
					ea_q = base + {8'h00, x_q};
				else if (cur_mode == MODE_ABY)
					ea_q = base + {8'h00, y_q};
				else
					ea_q = base;
				return read_request(ea_q, PH_VAL);
			end
			PH_PL: begin
				lo_q = it.read_data;
				// indirect jump keeps the high pointer byte on the same page
				if (cur_mode == MODE_IND)
					return read_request({ptr_q[15:8], ptr_next_lo}, PH_PH);
				return read_request({8'h00, ptr_next_lo}, PH_PH);
			end
			PH_PH: begin
				ptr_q = base;
				ea_q = (cur_mode == MODE_IZY) ? base + {8'h00, y_q} : base;
				return read_request(ea_q, PH_VAL);
			end
			PH_VAL: begin
				val_q = it.read_data;
				crossed = (cur_mode == MODE_ABX || cur_mode == MODE_ABY ||
					cur_mode == MODE_IZY) && (ptr_q[15:8] != ea_q[15:8]);
				return done_result(crossed ? EXTRA_CROSS : EXTRA_NONE);
			end
			// data while idle
			default: return done_result(EXTRA_NONE);
		endcase
	endfunction

	// Compare accepted results, then queue the prediction for an accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_phase = PH_IDLE;
			cur_mode = '0;
			pc_q = '0;
			x_q = '0;
			y_q = '0;
			lo_q = '0;
			ptr_q = '0;
			ea_q = '0;
			val_q = '0;
			fail_count = 0;
			awaited_results.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no request outstanding",
						result.bus_address, 16'h0000);
				end else begin
					want = awaited_results.pop_front();
					if (result.result_kind !== want.result_kind)
						report_mismatch("result_kind", 16'(result.result_kind),
							16'(want.result_kind));
					if (result.bus_address !== want.bus_address)
						report_mismatch("bus_address", result.bus_address, want.bus_address);
					if (result.next_pc !== want.next_pc)
						report_mismatch("next_pc", result.next_pc, want.next_pc);
					if (result.effective_address !== want.effective_address)
						report_mismatch("effective_address", result.effective_address,
							want.effective_address);
					if (result.operand_byte !== want.operand_byte)
						report_mismatch("operand_byte", 16'(result.operand_byte),
							16'(want.operand_byte));
					if (result.extra_cycles !== want.extra_cycles)
						report_mismatch("extra_cycles", 16'(result.extra_cycles),
							16'(want.extra_cycles));
				end
				results_seen++;
			end
			if (item_valid && item_ready)
				awaited_results.push_back(advance_sequencer(item));
		end
		pending = awaited_results.size();
	end

endmodule

// ===== tb/addressing_mode_operand_fetch_core_test.sv =====
`timescale 1ns / 100ps

module addressing_mode_operand_fetch_core_test;
	import amof_pkg::*;

	localparam int RANDOM_ITEMS   = 1700;
	localparam int WATCHDOG_LIMIT = 2000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	int      fail_count;
	int      pending;

	item_t   fetch_requests[$];
	int      idle_cycles = 0;

	// Receiver stall pattern state
	int      rx_style = 0;
	int      rx_left = 0;
	int      rx_period = 2;
	int      rx_tick = 0;

	addressing_mode_operand_fetch_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	addressing_mode_operand_fetch_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Bytes leaning toward the page and wrap boundaries
	function automatic logic [7:0] skewed_byte();
		case ($urandom_range(0, 7))
			0, 1: return 8'hFF;
			2: return 8'h00;
			3: return 8'hF0 | 8'($urandom_range(0, 15));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic item_t start_item(logic [3:0] m, logic [15:0] pc, logic [7:0] x,
			logic [7:0] y, logic [7:0] a);
		item_t it;
		it.item_kind = ITEM_START;
		it.mode = m;
		it.prog_counter = pc;
		it.index_x = x;
		it.index_y = y;
		it.accum = a;
		it.read_data = 8'($urandom);
		return it;
	endfunction

	// Data request; the unused fields carry noise
	function automatic item_t data_item(logic [7:0] d);
		item_t it;
		it.item_kind = ITEM_DATA;
		it.mode = 4'($urandom);
		it.prog_counter = 16'($urandom);
		it.index_x = 8'($urandom);
		it.index_y = 8'($urandom);
		it.accum = 8'($urandom);
		it.read_data = d;
		return it;
	endfunction

	// Data requests a mode takes from start to done
	function automatic int operand_reads(logic [3:0] m);
		case (m)
			MODE_IMM, MODE_REL: return 1;
			MODE_ZP, MODE_ZPX, MODE_ZPY: return 2;
			MODE_ABS, MODE_ABX, MODE_ABY: return 3;
			MODE_IZX, MODE_IZY: return 4;
			MODE_IND: return 5;
			default: return 0;
		endcase
	endfunction

	// Receiver: switches among randomly chosen stall styles
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = $urandom_range(0, 3);
			rx_period = $urandom_range(2, 6);
			rx_left = $urandom_range(50, 300);
		end
		rx_left--;
		rx_tick++;
		case (rx_style)
			0: result_ready <= 1'b1;
			1: result_ready <= ($urandom_range(0, 3) != 0);
			2: result_ready <= (rx_tick % rx_period == 0);
			default: result_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Watchdog on handshake progress
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("addressing_mode_operand_fetch_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int         idx;
		int         burst;
		int         gap;
		int         k;
		int         n;
		int         target;
		logic [3:0] m;

		// Directed: idle data, immediate finishes, wraps, page cross, page bug
		fetch_requests.push_back(data_item(8'hA5));
		fetch_requests.push_back(start_item(MODE_IMP, 16'h1234, 8'h00, 8'h00, 8'h00));
		fetch_requests.push_back(start_item(MODE_ACC, 16'h8000, 8'hFF, 8'hFF, 8'hFF));
		// undefined mode code acts as implied
		fetch_requests.push_back(start_item(4'hF, 16'hFFFF, 8'h55, 8'hAA, 8'h3C));
		fetch_requests.push_back(start_item(MODE_IMM, 16'hFFFF, 8'h01, 8'h02, 8'h00));
		fetch_requests.push_back(data_item(8'h00));
		fetch_requests.push_back(start_item(MODE_REL, 16'h0000, 8'h00, 8'h00, 8'h00));
		fetch_requests.push_back(data_item(8'h80));
		fetch_requests.push_back(start_item(MODE_ZPX, 16'h0200, 8'h20, 8'h00, 8'h00));
		fetch_requests.push_back(data_item(8'hF0));
		fetch_requests.push_back(data_item(8'h5A));
		// zero page sequence cut off by a new start
		fetch_requests.push_back(start_item(MODE_ZP, 16'h0300, 8'h00, 8'h00, 8'h00));
		fetch_requests.push_back(data_item(8'h44));
		fetch_requests.push_back(start_item(MODE_IZY, 16'h0400, 8'h00, 8'hFF, 8'h00));
		fetch_requests.push_back(data_item(8'hFF));
		fetch_requests.push_back(data_item(8'h34));
		fetch_requests.push_back(data_item(8'h12));
		fetch_requests.push_back(data_item(8'h77));
		fetch_requests.push_back(start_item(MODE_ABX, 16'hFFFE, 8'h01, 8'h00, 8'h00));
		fetch_requests.push_back(data_item(8'hFF));
		fetch_requests.push_back(data_item(8'hFF));
		fetch_requests.push_back(data_item(8'h01));
		fetch_requests.push_back(start_item(MODE_IND, 16'h0600, 8'h00, 8'h00, 8'h00));
		fetch_requests.push_back(data_item(8'hFF));
		fetch_requests.push_back(data_item(8'h12));
		fetch_requests.push_back(data_item(8'h00));
		fetch_requests.push_back(data_item(8'h80));
		fetch_requests.push_back(data_item(8'h99));

		// Random: mostly complete sequences, some cut short, some stray data
		target = fetch_requests.size() + RANDOM_ITEMS;
		while (fetch_requests.size() < target) begin
			m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
				: 4'($urandom_range(0, 12));
			case ($urandom_range(0, 9))
				8: n = (operand_reads(m) == 0) ? 0 : $urandom_range(0, operand_reads(m) - 1);
				9: n = -1;
				default: n = operand_reads(m);
			endcase
			if (n < 0) begin
				repeat ($urandom_range(1, 3))
					fetch_requests.push_back(data_item(8'($urandom)));
			end else begin
				fetch_requests.push_back(start_item(m,
					($urandom_range(0, 3) == 0) ? {8'hFF, 8'($urandom)} : 16'($urandom),
					skewed_byte(), skewed_byte(), 8'($urandom)));
				repeat (n)
					fetch_requests.push_back(data_item(skewed_byte()));
			end
		end

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender: bursts of random length with random gaps
		idx = 0;
		while (idx < fetch_requests.size()) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			for (k = 0; k < burst && idx < fetch_requests.size(); k++) begin
				item_valid <= 1'b1;
				item <= fetch_requests[idx];
				idx++;
				do @(posedge clk); while (!item_ready);
				@(negedge clk);
			end
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		item_valid <= 1'b0;

		// Drain outstanding results, then allow for stray ones
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("addressing_mode_operand_fetch_core regression: pass");
		else
			$display("addressing_mode_operand_fetch_core regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/amof_pkg.sv
hw/rtl/addressing_mode_operand_fetch_core.sv
hw/rtl/amof_checker.sv
tb/addressing_mode_operand_fetch_checker.sv
tb/addressing_mode_operand_fetch_core_test.sv
